// ----- hw/rtl/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the sprite screen projection block.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int DIV_STAGES  = 45;

  localparam logic [CFG_W-1:0] VIEW_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] VIEW_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_WIDTH,
    REG_VIEW_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        object_x;
    logic [15:0]        object_y;
    logic [15:0]        viewer_x;
    logic [15:0]        viewer_y;
    logic signed [15:0] facing_x;
    logic signed [15:0] facing_y;
    logic signed [15:0] camera_plane_x;
    logic signed [15:0] camera_plane_y;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] center_column;
    logic [15:0]        object_size;
    logic [11:0]        first_column;
    logic [11:0]        last_column;
    logic [11:0]        first_row;
    logic [11:0]        last_row;
    logic [15:0]        depth;
  } out_item_t;

  typedef struct packed {
    logic vis;
    logic c_neg;
    logic d_sat;
  } side_t;

endpackage

// ----- hw/rtl/ssp_stream_if.sv -----
// ----------------------------------------------------------------------------
// ssp_stream_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface ssp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ssp_div.sv -----
// ----------------------------------------------------------------------------
// ssp_div
// Pipelined restoring divider, up to one quotient bit per stage, shared stall.
// ----------------------------------------------------------------------------
module ssp_div #(
  parameter int N_W    = 45,
  parameter int D_W    = 39,
  parameter int Q_W    = 39,
  parameter int STAGES = 45
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  logic [N_W-1:0] rem_r [STAGES];
  logic [D_W-1:0] den_r [STAGES];
  logic [Q_W-1:0] quo_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [N_W-1:0] rem_in;
    logic [N_W-1:0] rem_out;
    logic [D_W-1:0] den_in;
    logic [Q_W-1:0] quo_in;
    logic [Q_W-1:0] quo_out;

    if (k == 0) begin : g_head
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    if (k < Q_W) begin : g_bit
      localparam int B = Q_W - 1 - k;
      localparam logic [Q_W-1:0] MASK = Q_W'(1) << B;
      logic take;
      assign take    = (rem_in >> B) >= N_W'(den_in);
      assign rem_out = take ? rem_in - (N_W'(den_in) << B) : rem_in;
      assign quo_out = take ? (quo_in | MASK) : quo_in;
    end else begin : g_pass
      assign rem_out = rem_in;
      assign quo_out = quo_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_out;
        den_r[k] <= den_in;
        quo_r[k] <= quo_out;
      end
    end
  end

  assign quo = quo_r[STAGES-1];

endmodule

// ----- hw/rtl/sprite_screen_projection.sv -----
// ----------------------------------------------------------------------------
// sprite_screen_projection
// Projects one object onto the screen: camera transform, centre column,
// square size, clamped row/column range and depth.
//
//   channel  | dir | handshake           | payload
//   in_req   | in  | valid/ready         | object, viewer, facing, plane
//   out_res  | out | valid/ready         | visibility, placement, depth
//   cfg      | in  | cfg_we              | view_width, view_height
//
// One request per cycle while out_res is not stalled. Stages: four setup
// stages, 45 divider stages (at most one quotient bit each, three dividers
// side by side), one bound stage and the output register. A stall on out_res
// freezes every stage; nothing is dropped or repeated. Reset clears all valid
// bits and loads the view registers with 640 x 480.
// ----------------------------------------------------------------------------
module sprite_screen_projection (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ssp_stream_if.sink                            in_req,
  ssp_stream_if.source                          out_res,
  input  logic                                  cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssp_pkg::CFG_W-1:0]             cfg_wdata
);
  import ssp_pkg::*;

  logic [CFG_W-1:0] w_r, h_r;
  logic             en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= VIEW_WIDTH_RST;
      h_r <= VIEW_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEW_WIDTH:  w_r <= cfg_wdata;
        REG_VIEW_HEIGHT: h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en           = !out_valid_r || out_res.ready;
  assign in_req.ready = en;

  // stage 1: offsets and products
  logic               s1_v_r;
  logic signed [31:0] s1_da_r, s1_db_r;
  logic signed [32:0] s1_xa_r, s1_xb_r, s1_ya_r, s1_yb_r;
  logic signed [16:0] dx, dy;

  assign dx = $signed({1'b0, in_req.data.object_x}) - $signed({1'b0, in_req.data.viewer_x});
  assign dy = $signed({1'b0, in_req.data.object_y}) - $signed({1'b0, in_req.data.viewer_y});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_da_r <= in_req.data.camera_plane_x * in_req.data.facing_y;
      s1_db_r <= in_req.data.facing_x * in_req.data.camera_plane_y;
      s1_xa_r <= in_req.data.facing_y * dx;
      s1_xb_r <= in_req.data.facing_x * dy;
      s1_ya_r <= in_req.data.camera_plane_x * dy;
      s1_yb_r <= in_req.data.camera_plane_y * dx;
    end
  end

  // stage 2: determinant, sign normalization
  logic               s2_v_r;
  logic [31:0]        s2_det_r;
  logic signed [33:0] s2_nx_r, s2_ny_r;
  logic signed [32:0] det_s;
  logic signed [33:0] nx_s, ny_s;

  assign det_s = s1_da_r - s1_db_r;
  assign nx_s  = s1_xa_r - s1_xb_r;
  assign ny_s  = s1_ya_r - s1_yb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_det_r <= det_s[32] ? 32'(-det_s) : 32'(det_s);
      s2_nx_r  <= det_s[32] ? -nx_s : nx_s;
      s2_ny_r  <= det_s[32] ? -ny_s : ny_s;
    end
  end

  // stage 3: centre numerator sum, visibility, depth overflow
  logic               s3_v_r;
  logic signed [34:0] s3_sum_r;
  logic [32:0]        s3_ny_r;
  logic [31:0]        s3_det_r;
  logic               s3_vis_r, s3_dsat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r  <= 35'(s2_nx_r) + 35'(s2_ny_r);
      s3_ny_r   <= s2_ny_r[32:0];
      s3_det_r  <= s2_det_r;
      s3_vis_r  <= (s2_det_r != '0) && !s2_ny_r[33] && (s2_ny_r != '0);
      s3_dsat_r <= {1'b0, s2_ny_r[32:0]} >= {s2_det_r, 2'b00};
    end
  end

  // stage 4: dividends and divisors
  logic               s4_v_r;
  logic [44:0]        s4_num_c_r, s4_num_s_r;
  logic [32:0]        s4_ny_r;
  logic [31:0]        s4_det_r;
  side_t              s4_side_r;
  logic [33:0]        sum_abs;
  logic [45:0]        prod_c;
  logic [44:0]        prod_s;

  assign sum_abs = s3_sum_r[34] ? 34'(-s3_sum_r) : 34'(s3_sum_r);
  assign prod_c  = w_r[12:1] * sum_abs;
  assign prod_s  = h_r * s3_det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num_c_r <= prod_c[44:0];
      s4_num_s_r <= prod_s;
      s4_ny_r    <= s3_ny_r;
      s4_det_r   <= s3_det_r;
      s4_side_r  <= '{vis: s3_vis_r, c_neg: s3_sum_r[34], d_sat: s3_dsat_r};
    end
  end

  // dividers
  logic [44:0] q_c;
  logic [38:0] q_s;
  logic [15:0] q_d;

  ssp_div #(.N_W(45), .D_W(33), .Q_W(45), .STAGES(DIV_STAGES)) u_div_center (
    .clk (clk), .en (en), .num (s4_num_c_r), .den (s4_ny_r), .quo (q_c)
  );

  ssp_div #(.N_W(45), .D_W(39), .Q_W(39), .STAGES(DIV_STAGES)) u_div_size (
    .clk (clk), .en (en), .num (s4_num_s_r), .den ({s4_ny_r, 6'b0}), .quo (q_s)
  );

  ssp_div #(.N_W(47), .D_W(32), .Q_W(16), .STAGES(DIV_STAGES)) u_div_depth (
    .clk (clk), .en (en), .num ({s4_ny_r, 14'b0}), .den (s4_det_r), .quo (q_d)
  );

  logic  dv_r   [DIV_STAGES];
  side_t side_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= (k == 0) ? s4_side_r : side_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= (k == 0) ? s4_v_r : dv_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // bound stage
  logic               e_v_r;
  side_t              e_side_r;
  logic signed [45:0] e_ctr_r;
  logic [38:0]        e_size_r;
  logic signed [46:0] e_fc_r, e_lc_r;
  logic signed [39:0] e_fr_r;
  logic [38:0]        e_lr_r;
  logic [15:0]        e_dep_r;
  logic signed [45:0] ctr;
  logic [37:0]        half;

  assign ctr  = side_r[DIV_STAGES-1].c_neg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
  assign half = q_s[38:1];

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= side_r[DIV_STAGES-1];
      e_ctr_r  <= ctr;
      e_size_r <= q_s;
      e_fc_r   <= 47'(ctr) - $signed({9'b0, half});
      e_lc_r   <= 47'(ctr) + $signed({9'b0, half});
      e_fr_r   <= $signed({28'b0, h_r[12:1]}) - $signed({2'b0, half});
      e_lr_r   <= {1'b0, half} + 39'(h_r[12:1]);
      e_dep_r  <= q_d;
    end
  end

  // valid chain of the setup and bound stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      e_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_req.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      e_v_r  <= dv_r[DIV_STAGES-1];
    end
  end

  // saturation and screen clamps
  out_item_t out_nxt;
  out_item_t out_r;

  always_comb begin
    out_nxt = '0;
    if (e_side_r.vis) begin
      out_nxt.visible = 1'b1;
      if (e_ctr_r > 46'sd32767) begin
        out_nxt.center_column = 16'sh7fff;
      end else if (e_ctr_r < -46'sd32768) begin
        out_nxt.center_column = 16'sh8000;
      end else begin
        out_nxt.center_column = e_ctr_r[15:0];
      end
      out_nxt.object_size = (|e_size_r[38:16]) ? 16'hffff : e_size_r[15:0];
      if (e_fc_r < 0) begin
        out_nxt.first_column = '0;
      end else if (e_fc_r > 47'sd4095) begin
        out_nxt.first_column = 12'hfff;
      end else begin
        out_nxt.first_column = e_fc_r[11:0];
      end
      if (e_lc_r >= $signed({34'b0, w_r})) begin
        if (w_r == '0) begin
          out_nxt.last_column = '0;
        end else if (w_r > 13'd4096) begin
          out_nxt.last_column = 12'hfff;
        end else begin
          out_nxt.last_column = 12'(w_r - 13'd1);
        end
      end else if (e_lc_r < 0) begin
        out_nxt.last_column = '0;
      end else if (e_lc_r > 47'sd4095) begin
        out_nxt.last_column = 12'hfff;
      end else begin
        out_nxt.last_column = e_lc_r[11:0];
      end
      if (e_fr_r < 0) begin
        out_nxt.first_row = '0;
      end else if (e_fr_r > 40'sd4095) begin
        out_nxt.first_row = 12'hfff;
      end else begin
        out_nxt.first_row = e_fr_r[11:0];
      end
      if (e_lr_r >= 39'(h_r)) begin
        if (h_r == '0) begin
          out_nxt.last_row = '0;
        end else if (h_r > 13'd4096) begin
          out_nxt.last_row = 12'hfff;
        end else begin
          out_nxt.last_row = 12'(h_r - 13'd1);
        end
      end else if (e_lr_r > 39'd4095) begin
        out_nxt.last_row = 12'hfff;
      end else begin
        out_nxt.last_row = e_lr_r[11:0];
      end
      out_nxt.depth = e_side_r.d_sat ? 16'hffff : e_dep_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_r;

endmodule
